// ----- rtl/k_way_sorted_merge_macros.svh -----
// Assertion macros shared by the merge engine RTL.
// Depends on nothing; the asserting module supplies clk and rst_n.
`ifndef K_WAY_SORTED_MERGE_MACROS_SVH
`define K_WAY_SORTED_MERGE_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define KSM_ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error(msg);

// Concurrent assertion on the module's own clk and rst_n.
`define KSM_ASSERT(label, prop, msg) `KSM_ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

// ----- rtl/ksm_pkg.sv -----
// Shared constants for the k-way merge engine: request kinds, status codes and
// stream widths. Depends on nothing.
`default_nettype none

package ksm_pkg;

    localparam int KEY_W        = 32;
    localparam int LANE_FIELD_W = 3;
    localparam int STATUS_W     = 2;
    localparam int ACTIVE_W     = 4;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 40;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

endpackage

`default_nettype wire

// ----- rtl/ksm_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module ksm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                      clk,
    input  wire                      wr_en,
    input  wire  [$clog2(DEPTH)-1:0] wr_addr,
    input  wire  [WIDTH-1:0]         wr_data,
    input  wire                      rd_en,
    input  wire  [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/k_way_sorted_merge.sv -----
// k-way merge engine: one queue of signed keys per lane, pop returns the least head.
// Depends on ksm_pkg, ksm_ram and k_way_sorted_merge_macros.svh.
//
// Usage. Requests arrive on the s_ stream: tuser selects push or pop, tdata carries
// the lane and key of a push. Every request gives exactly one transfer on the m_
// stream: the popped key and its lane in tdata, the status in tuser, and tlast
// set when a pop leaves every active lane empty. The cfg channel writes the
// number of active lanes at any time it is ready; it is meant to change only
// while no request is in flight.
// Sequence: a push reads its lane state, then writes the key and the new lane state,
// then moves its result to the output register; the engine takes the next request
// only once it is back in idle. A push to a lane that is out of range goes straight
// to the output register. A pop scans the active lanes one per cycle through the
// lane-state memory and then the key memory, then writes back the chosen lane's
// state and moves its result to the output register; no request is taken during
// the scan.
// Reset empties every lane at once (per-lane valid bits) and sets eight active
// lanes; no clearing pass is needed. While the receiver stalls, a finished
// result waits in the output register and the next request is still taken;
// the engine holds a second result until the output register is free.
`default_nettype none
`include "k_way_sorted_merge_macros.svh"

module k_way_sorted_merge #(
    parameter int LANES      = 8,
    parameter int LANE_DEPTH = 64,
    parameter int KEY_BITS   = 32
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // lane [2:0], key [34:3], zero [39:35]
    input  wire  [ksm_pkg::IN_TDATA_W-1:0]   s_tdata,
    // req_type [0]
    input  wire  [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // out_key [31:0], out_lane [34:32], zero [39:35]
    output logic [ksm_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // status [1:0]
    output logic [ksm_pkg::STATUS_W-1:0]     m_tuser,
    output logic                             m_tlast,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [ksm_pkg::ACTIVE_W-1:0]     cfg_data
);

    import ksm_pkg::*;

    localparam int LANE_W  = $clog2(LANES);
    localparam int PTR_W   = $clog2(LANE_DEPTH);
    localparam int FILL_W  = $clog2(LANE_DEPTH + 1);
    localparam int ACT_W   = ($clog2(LANES + 1) > ACTIVE_W) ? $clog2(LANES + 1) : ACTIVE_W;
    localparam int CNT_W   = ACT_W + 1;
    localparam int KDEPTH  = LANES * LANE_DEPTH;
    localparam int KA_W    = $clog2(KDEPTH);
    localparam int STATE_W = 2 * PTR_W + FILL_W;

    localparam logic [ACT_W-1:0]  LANES_A   = ACT_W'(LANES);
    localparam logic [ACT_W-1:0]  ONE_A     = ACT_W'(1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(LANE_DEPTH);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(LANE_DEPTH - 1);
    localparam logic [KA_W-1:0]   DEPTH_K   = KA_W'(LANE_DEPTH);

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic [PTR_W-1:0]  wr;
        logic [PTR_W-1:0]  rd;
    } lane_state_t;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_PUSH_WR  = 5'b00010,
        ST_POP_SCAN = 5'b00100,
        ST_POP_FIN  = 5'b01000,
        ST_EMIT     = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [ACTIVE_W-1:0] active_reg;
    logic [LANES-1:0]    lane_valid_reg;
    logic                lane_rvalid_reg;

    logic [LANE_W-1:0]   req_lane_reg, req_lane_next;
    logic signed [KEY_W-1:0] req_key_reg, req_key_next;

    logic [CNT_W-1:0]    scan_cnt_reg, scan_cnt_next;
    logic                a_vld_reg;
    logic [LANE_W-1:0]   a_lane_reg;
    logic                b_vld_reg;
    logic [LANE_W-1:0]   b_lane_reg;
    lane_state_t         b_state_reg;

    logic                found_reg, found_next;
    logic                seen_reg, seen_next;
    logic                multi_reg, multi_next;
    logic [LANE_W-1:0]   best_lane_reg, best_lane_next;
    logic signed [KEY_BITS-1:0] best_key_reg, best_key_next;
    lane_state_t         best_state_reg, best_state_next;

    logic signed [KEY_W-1:0]  res_key_reg, res_key_next;
    logic [LANE_FIELD_W-1:0]  res_lane_reg, res_lane_next;
    logic [STATUS_W-1:0]      res_status_reg, res_status_next;
    logic                     res_last_reg, res_last_next;

    logic                     m_tvalid_reg;
    logic [KEY_W-1:0]         m_key_reg;
    logic [LANE_FIELD_W-1:0]  m_lane_reg;
    logic [STATUS_W-1:0]      m_status_reg;
    logic                     m_last_reg;

    logic [ACT_W-1:0]    act_eff;
    logic [ACT_W-1:0]    in_lane_wide;
    logic [LANE_W-1:0]   in_lane;
    logic                in_accept;
    logic                scan_issue;
    logic                out_load;

    logic                lane_rd_en;
    logic [LANE_W-1:0]   lane_rd_addr;
    logic [STATE_W-1:0]  lane_rdata;
    logic                lane_wr_en;
    logic [LANE_W-1:0]   lane_wr_addr;
    lane_state_t         lane_wr_data;
    lane_state_t         lane_cur;

    logic                key_rd_en;
    logic [KA_W-1:0]     key_rd_addr;
    logic [KEY_BITS-1:0] key_rdata;
    logic                key_wr_en;
    logic [KA_W-1:0]     key_wr_addr;
    logic [KEY_BITS-1:0] key_wr_data;
    logic signed [KEY_BITS-1:0] cand_key;
    logic                take;

    ksm_ram #(
        .WIDTH (STATE_W),
        .DEPTH (LANES)
    ) u_lane_ram (
        .clk     (clk),
        .wr_en   (lane_wr_en),
        .wr_addr (lane_wr_addr),
        .wr_data (lane_wr_data),
        .rd_en   (lane_rd_en),
        .rd_addr (lane_rd_addr),
        .rd_data (lane_rdata)
    );

    ksm_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (KDEPTH)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (key_wr_addr),
        .wr_data (key_wr_data),
        .rd_en   (key_rd_en),
        .rd_addr (key_rd_addr),
        .rd_data (key_rdata)
    );

    always_comb
    begin
        if (active_reg == '0)
        begin
            act_eff = ONE_A;
        end
        else if (ACT_W'(active_reg) > LANES_A)
        begin
            act_eff = LANES_A;
        end
        else
        begin
            act_eff = ACT_W'(active_reg);
        end
    end

    assign cfg_ready    = 1'b1;
    assign s_tready     = (state_reg == ST_IDLE);
    assign in_accept    = s_tvalid && s_tready;
    assign in_lane_wide = ACT_W'(s_tdata[LANE_FIELD_W-1:0]);
    assign in_lane      = in_lane_wide[LANE_W-1:0];
    assign scan_issue   = (state_reg == ST_POP_SCAN) && (scan_cnt_reg < CNT_W'(act_eff));
    assign out_load     = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    assign lane_cur = lane_rvalid_reg ? lane_state_t'(lane_rdata) : '0;
    assign cand_key = key_rdata;
    assign take     = b_vld_reg && (!found_reg || (cand_key < best_key_reg));

    always_comb
    begin
        lane_rd_en   = 1'b0;
        lane_rd_addr = in_lane;
        if (state_reg == ST_IDLE)
        begin
            lane_rd_en   = in_accept && (s_tuser[0] == REQ_PUSH);
            lane_rd_addr = in_lane;
        end
        else if (scan_issue)
        begin
            lane_rd_en   = 1'b1;
            lane_rd_addr = scan_cnt_reg[LANE_W-1:0];
        end
    end

    assign key_rd_en   = a_vld_reg;
    assign key_rd_addr = KA_W'(a_lane_reg) * DEPTH_K + KA_W'(lane_cur.rd);
    assign key_wr_addr = KA_W'(req_lane_reg) * DEPTH_K + KA_W'(lane_cur.wr);
    assign key_wr_data = KEY_BITS'(req_key_reg);
    assign key_wr_en   = (state_reg == ST_PUSH_WR) && (lane_cur.fill < FULL_FILL);

    always_comb
    begin
        lane_wr_en   = 1'b0;
        lane_wr_addr = req_lane_reg;
        lane_wr_data = lane_cur;
        if (state_reg == ST_PUSH_WR)
        begin
            lane_wr_en   = key_wr_en;
            lane_wr_addr = req_lane_reg;
            lane_wr_data.rd   = lane_cur.rd;
            lane_wr_data.wr   = (lane_cur.wr == PTR_LAST) ? '0 : lane_cur.wr + 1'b1;
            lane_wr_data.fill = lane_cur.fill + 1'b1;
        end
        else if (state_reg == ST_POP_FIN)
        begin
            lane_wr_en   = found_reg;
            lane_wr_addr = best_lane_reg;
            lane_wr_data.rd   = (best_state_reg.rd == PTR_LAST) ? '0 : best_state_reg.rd + 1'b1;
            lane_wr_data.wr   = best_state_reg.wr;
            lane_wr_data.fill = best_state_reg.fill - 1'b1;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        req_lane_next   = req_lane_reg;
        req_key_next    = req_key_reg;
        scan_cnt_next   = scan_cnt_reg;
        found_next      = found_reg;
        seen_next       = seen_reg;
        multi_next      = multi_reg;
        best_lane_next  = best_lane_reg;
        best_key_next   = best_key_reg;
        best_state_next = best_state_reg;
        res_key_next    = res_key_reg;
        res_lane_next   = res_lane_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    req_lane_next   = in_lane;
                    req_key_next    = s_tdata[LANE_FIELD_W +: KEY_W];
                    res_key_next    = '0;
                    res_lane_next   = '0;
                    res_status_next = STATUS_OK;
                    res_last_next   = 1'b0;
                    if (s_tuser[0] == REQ_POP)
                    begin
                        scan_cnt_next = '0;
                        found_next    = 1'b0;
                        seen_next     = 1'b0;
                        multi_next    = 1'b0;
                        state_next    = ST_POP_SCAN;
                    end
                    else if (in_lane_wide >= act_eff)
                    begin
                        res_status_next = STATUS_RANGE;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_PUSH_WR;
                    end
                end
            end
            ST_PUSH_WR:
            begin
                if (!key_wr_en)
                begin
                    res_status_next = STATUS_FULL;
                end
                state_next = ST_EMIT;
            end
            ST_POP_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (b_vld_reg)
                begin
                    seen_next = 1'b1;
                    if (seen_reg)
                    begin
                        multi_next = 1'b1;
                    end
                end
                if (take)
                begin
                    found_next      = 1'b1;
                    best_lane_next  = b_lane_reg;
                    best_key_next   = cand_key;
                    best_state_next = b_state_reg;
                end
                if (scan_cnt_reg == CNT_W'(act_eff) + 1'b1)
                begin
                    state_next = ST_POP_FIN;
                end
            end
            ST_POP_FIN:
            begin
                if (found_reg)
                begin
                    res_key_next    = KEY_W'(best_key_reg);
                    res_lane_next   = LANE_FIELD_W'(best_lane_reg);
                    res_status_next = STATUS_OK;
                    res_last_next   = !multi_reg && (best_state_reg.fill == FILL_W'(1));
                end
                else
                begin
                    res_status_next = STATUS_EMPTY;
                    res_last_next   = 1'b1;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            active_reg      <= ACTIVE_RESET;
            lane_valid_reg  <= '0;
            lane_rvalid_reg <= 1'b0;
            scan_cnt_reg    <= '0;
            a_vld_reg       <= 1'b0;
            b_vld_reg       <= 1'b0;
            found_reg       <= 1'b0;
            seen_reg        <= 1'b0;
            multi_reg       <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            lane_rvalid_reg <= lane_rd_en && lane_valid_reg[lane_rd_addr];
            scan_cnt_reg    <= scan_cnt_next;
            a_vld_reg       <= scan_issue;
            b_vld_reg       <= a_vld_reg && (lane_cur.fill != '0);
            found_reg       <= found_next;
            seen_reg        <= seen_next;
            multi_reg       <= multi_next;
            if (cfg_valid && cfg_ready)
            begin
                active_reg <= cfg_data;
            end
            if (lane_wr_en)
            begin
                lane_valid_reg[lane_wr_addr] <= 1'b1;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_lane_reg   <= req_lane_next;
        req_key_reg    <= req_key_next;
        a_lane_reg     <= scan_cnt_reg[LANE_W-1:0];
        b_lane_reg     <= a_lane_reg;
        b_state_reg    <= lane_cur;
        best_lane_reg  <= best_lane_next;
        best_key_reg   <= best_key_next;
        best_state_reg <= best_state_next;
        res_key_reg    <= res_key_next;
        res_lane_reg   <= res_lane_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
        if (out_load)
        begin
            m_key_reg    <= res_key_reg;
            m_lane_reg   <= res_lane_reg;
            m_status_reg <= res_status_reg;
            m_last_reg   <= res_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - KEY_W - LANE_FIELD_W){1'b0}}, m_lane_reg, m_key_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    `KSM_ASSERT(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready, "request taken while busy")
    `KSM_ASSERT(a_push_has_room, key_wr_en |-> (lane_cur.fill < FULL_FILL), "push into full lane")
    `KSM_ASSERT(a_pop_from_filled,
        (state_reg == ST_POP_FIN && found_reg) |-> (best_state_reg.fill != '0),
        "pop from empty lane")
    `KSM_ASSERT(a_empty_is_last, (m_tvalid && m_tuser == STATUS_EMPTY) |-> m_tlast, "empty not last")

endmodule

`default_nettype wire

// ----- sim/ksm_merge_checker.sv -----
// Checker for the k-way merge engine: tracks lane contents and the active lane count,
// predicts one result per request transfer and compares it with the result stream.
// Depends on ksm_pkg for widths, request kinds and status codes.
`timescale 1ns / 1ps

module ksm_merge_checker #(
    parameter int LANES      = 8,
    parameter int LANE_DEPTH = 64
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    input  wire                              s_tready,
    // lane [2:0], key [34:3], zero [39:35]
    input  wire  [ksm_pkg::IN_TDATA_W-1:0]   s_tdata,
    // req_type [0]
    input  wire  [0:0]                       s_tuser,
    input  wire                              m_tvalid,
    input  wire                              m_tready,
    // out_key [31:0], out_lane [34:32], zero [39:35]
    input  wire  [ksm_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // status [1:0]
    input  wire  [ksm_pkg::STATUS_W-1:0]     m_tuser,
    input  wire                              m_tlast,
    input  wire                              cfg_valid,
    input  wire                              cfg_ready,
    input  wire  [ksm_pkg::ACTIVE_W-1:0]     cfg_data,
    output int                               fail_count,
    output int                               pending,
    output int                               keys_popped,
    output int                               empty_pops,
    output int                               full_pushes,
    output int                               range_pushes
);

    localparam int REPORT_LIMIT = 30;

    typedef struct packed {
        logic [ksm_pkg::KEY_W-1:0]        key;
        logic [ksm_pkg::LANE_FIELD_W-1:0] ln;
        logic [ksm_pkg::STATUS_W-1:0]     st;
        logic                             last;
    } merge_result_t;

    logic [ksm_pkg::KEY_W-1:0]    lane_keys [LANES][LANE_DEPTH];
    int unsigned                  head_pos  [LANES];
    int unsigned                  tail_pos  [LANES];
    int unsigned                  lane_used [LANES];
    logic [ksm_pkg::ACTIVE_W-1:0] active_setting;
    merge_result_t                awaited_results [$];
    int                           reports_shown;

    function automatic int unsigned lanes_in_merge();
        if (active_setting == 0)
        begin
            return 1;
        end
        if (active_setting > LANES)
        begin
            return LANES;
        end
        return active_setting;
    endfunction

    function automatic merge_result_t next_merge_result(logic req, logic [2:0] ln,
                                                        logic [31:0] k);
        merge_result_t r;
        int unsigned   n;
        bit            found;
        int unsigned   best;
        logic [31:0]   best_key;
        r        = '0;
        n        = lanes_in_merge();
        found    = 1'b0;
        best     = 0;
        best_key = '0;
        if (req == ksm_pkg::REQ_PUSH)
        begin
            if (ln >= n)
            begin
                r.st = ksm_pkg::STATUS_RANGE;
            end
            else if (lane_used[ln] >= LANE_DEPTH)
            begin
                r.st = ksm_pkg::STATUS_FULL;
            end
            else
            begin
                lane_keys[ln][tail_pos[ln]] = k;
                tail_pos[ln] = (tail_pos[ln] + 1) % LANE_DEPTH;
                lane_used[ln]++;
            end
        end
        else
        begin
            for (int l = 0; l < n; l++)
            begin
                if (lane_used[l] != 0 &&
                    (!found || $signed(lane_keys[l][head_pos[l]]) < $signed(best_key)))
                begin
                    found    = 1'b1;
                    best     = l;
                    best_key = lane_keys[l][head_pos[l]];
                end
            end
            r.last = 1'b1;
            if (!found)
            begin
                r.st = ksm_pkg::STATUS_EMPTY;
            end
            else
            begin
                head_pos[best] = (head_pos[best] + 1) % LANE_DEPTH;
                lane_used[best]--;
                r.key = best_key;
                r.ln  = best[2:0];
                for (int l = 0; l < n; l++)
                begin
                    if (lane_used[l] != 0)
                    begin
                        r.last = 1'b0;
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_streams
        merge_result_t got;
        merge_result_t want;
        if (!rst_n)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                head_pos[l]  = 0;
                tail_pos[l]  = 0;
                lane_used[l] = 0;
            end
            active_setting = ksm_pkg::ACTIVE_RESET;
            awaited_results.delete();
            pending      = 0;
            keys_popped  = 0;
            empty_pops   = 0;
            full_pushes  = 0;
            range_pushes = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.key  = m_tdata[31:0];
                got.ln   = m_tdata[34:32];
                got.st   = m_tuser;
                got.last = m_tlast;
                if (awaited_results.size() == 0)
                begin
                    fail_count++;
                    if (reports_shown < REPORT_LIMIT)
                    begin
                        $display("%0t: unexpected result transfer, key %0d lane %0d status %0d",
                                 $time, $signed(got.key), got.ln, got.st);
                    end
                    reports_shown++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.key !== want.key || got.ln !== want.ln ||
                        got.st !== want.st || got.last !== want.last)
                    begin
                        fail_count++;
                        if (reports_shown < REPORT_LIMIT)
                        begin
                            $display({"%0t: mismatch, expected key %0d lane %0d status %0d ",
                                      "last %0b, got key %0d lane %0d status %0d last %0b"},
                                     $time, $signed(want.key), want.ln, want.st, want.last,
                                     $signed(got.key), got.ln, got.st, got.last);
                        end
                        reports_shown++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                active_setting = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                want = next_merge_result(s_tuser[0], s_tdata[2:0], s_tdata[34:3]);
                awaited_results = {awaited_results, want};
                if (s_tuser[0] == ksm_pkg::REQ_POP && want.st == ksm_pkg::STATUS_OK)
                begin
                    keys_popped++;
                end
                if (want.st == ksm_pkg::STATUS_EMPTY)
                begin
                    empty_pops++;
                end
                if (want.st == ksm_pkg::STATUS_FULL)
                begin
                    full_pushes++;
                end
                if (want.st == ksm_pkg::STATUS_RANGE)
                begin
                    range_pushes++;
                end
            end
            pending = awaited_results.size();
        end
    end

endmodule

// ----- sim/k_way_sorted_merge_tb.sv -----
// Top of the k-way merge engine testbench: clock, reset, request and lane-count stimulus,
// result-side back-pressure, watchdog and verdict.
// Depends on ksm_pkg, k_way_sorted_merge and ksm_merge_checker.
`timescale 1ns / 1ps

module k_way_sorted_merge_tb;

    localparam int LANES         = 8;
    localparam int LANE_DEPTH    = 64;
    localparam int IDLE_LIMIT    = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 152;

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [ksm_pkg::IN_TDATA_W-1:0]   s_tdata;
    logic [0:0]                       s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [ksm_pkg::OUT_TDATA_W-1:0]  m_tdata;
    logic [ksm_pkg::STATUS_W-1:0]     m_tuser;
    logic                             m_tlast;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [ksm_pkg::ACTIVE_W-1:0]     cfg_data;

    int fail_count;
    int pending;
    int keys_popped;
    int empty_pops;
    int full_pushes;
    int range_pushes;
    int requests_sent;
    int settings_used;
    bit tx_idle;
    bit hold_req;

    k_way_sorted_merge #(
        .LANES      (LANES),
        .LANE_DEPTH (LANE_DEPTH),
        .KEY_BITS   (32)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    ksm_merge_checker #(
        .LANES      (LANES),
        .LANE_DEPTH (LANE_DEPTH)
    ) merge_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .keys_popped  (keys_popped),
        .empty_pops   (empty_pops),
        .full_pushes  (full_pushes),
        .range_pushes (range_pushes)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int burst_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return 1;
        end
        if (r < 95)
        begin
            return $urandom_range(2, 4);
        end
        return $urandom_range(15, 60);
    endfunction

    // Result side: random stalls in alternating busy and quiet stretches, plus one long
    // hold-off on request so that the engine backs up into its request input.
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        int tick;
        bit rx_idle;
        stall_left = 0;
        hold_left  = 0;
        tick       = 0;
        rx_idle    = 1'b1;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (tick % 300 == 0)
            begin
                rx_idle = ~rx_idle;
            end
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready = 1'b0;
            end
            else
            begin
                m_tready = 1'b1;
                if (rx_idle && $urandom_range(0, 99) < 30)
                begin
                    stall_left = burst_len();
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("%0t: watchdog expired after %0d cycles without a transfer", $time, quiet);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_req(logic req, logic [2:0] ln, logic [31:0] k);
        int gap;
        gap = 0;
        if (tx_idle && $urandom_range(0, 99) < 30)
        begin
            gap = burst_len();
        end
        @(negedge clk);
        repeat (gap)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = {5'b0, k, ln};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        requests_sent++;
    endtask

    task automatic send_pop();
        send_req(ksm_pkg::REQ_POP, 3'($urandom_range(0, 7)), $urandom());
    endtask

    // Lane count changes only once every awaited result has come back and the engine
    // has had time to finish any scan still under way.
    task automatic write_active(logic [3:0] value);
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        settings_used++;
    endtask

    initial
    begin : stimulus
        logic [3:0]  setting [PHASES];
        int          push_pct [PHASES];
        logic [31:0] run_key [LANES];
        logic [31:0] r;
        logic [31:0] k;
        logic [2:0]  ln;
        int unsigned act_eff;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        tx_idle   = 1'b1;
        setting   = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'($urandom_range(0, 15)), 4'd2,
                      4'd8, 4'd9, 4'd6, 4'($urandom_range(0, 15)), 4'd8};
        push_pct  = '{60, 92, 75, 35, 80, 50, 70, 65, 40, 85, 50, 30};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Extreme keys, ties between lanes and a drain past empty with all eight lanes.
        send_pop();
        send_req(ksm_pkg::REQ_PUSH, 3'd0, 32'h7FFF_FFFF);
        send_req(ksm_pkg::REQ_PUSH, 3'd1, 32'h8000_0000);
        send_req(ksm_pkg::REQ_PUSH, 3'd7, 32'h0000_0000);
        send_req(ksm_pkg::REQ_PUSH, 3'd3, 32'hFFFF_FFFF);
        send_req(ksm_pkg::REQ_PUSH, 3'd5, 32'd5);
        send_req(ksm_pkg::REQ_PUSH, 3'd6, 32'd5);
        send_req(ksm_pkg::REQ_PUSH, 3'd2, 32'd5);
        send_req(ksm_pkg::REQ_PUSH, 3'd4, 32'hAAAA_AAAA);
        repeat (9) send_pop();
        // Pushes beyond the active count, then a lane that keeps its key while inactive.
        write_active(4'd3);
        send_req(ksm_pkg::REQ_PUSH, 3'd3, 32'd1);
        send_req(ksm_pkg::REQ_PUSH, 3'd7, 32'h5555_5555);
        send_req(ksm_pkg::REQ_PUSH, 3'd0, 32'd9);
        send_req(ksm_pkg::REQ_PUSH, 3'd2, 32'd9);
        write_active(4'd0);
        send_pop();
        send_pop();
        write_active(4'd15);
        send_pop();

        // Mostly ascending runs per lane with random steps and ties, some random keys.
        for (int p = 0; p < PHASES; p++)
        begin
            write_active(setting[p]);
            act_eff = (setting[p] == 0) ? 1 : (setting[p] > LANES) ? LANES : setting[p];
            tx_idle = (p % 3 != 2);
            for (int l = 0; l < LANES; l++)
            begin
                r = $urandom();
                run_key[l] = {{3{r[31]}}, r[31:3]};
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 7 && i == 10)
                begin
                    hold_req = 1'b1;
                end
                if ($urandom_range(0, 99) < push_pct[p])
                begin
                    if ($urandom_range(0, 99) < 85)
                    begin
                        ln = 3'($urandom_range(0, act_eff - 1));
                    end
                    else
                    begin
                        ln = 3'($urandom_range(0, 7));
                    end
                    if ($urandom_range(0, 9) == 0)
                    begin
                        k = $urandom();
                    end
                    else
                    begin
                        k = run_key[ln];
                        if ($signed(run_key[ln]) > $signed(32'h7FF0_0000))
                        begin
                            r = $urandom();
                            run_key[ln] = {{3{r[31]}}, r[31:3]};
                        end
                        else if ($urandom_range(0, 3) != 0)
                        begin
                            run_key[ln] = run_key[ln] + $urandom_range(1, 5000);
                        end
                    end
                    send_req(ksm_pkg::REQ_PUSH, ln, k);
                end
                else
                begin
                    send_pop();
                end
            end
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d requests over %0d lane-count settings with one long stall.",
                 requests_sent, settings_used);
        $display("Keys popped %0d, empty pops %0d, full-lane pushes %0d, out-of-range pushes %0d.",
                 keys_popped, empty_pops, full_pushes, range_pushes);
        if (fail_count == 0 && pending == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
